// ===== rtl/watchdog_liveness_voter_assert.svh =====
// Assertion macros for the watchdog liveness voter.
// Used by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef WATCHDOG_LIVENESS_VOTER_ASSERT_SVH
`define WATCHDOG_LIVENESS_VOTER_ASSERT_SVH

// Same-cycle implication, masked during reset
`define WLV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog voter check failed");

// Next-cycle implication, masked during reset
`define WLV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog voter check failed");

`endif

// ===== rtl/wlv_pkg.sv =====
// Shared constants, command/status types and states for the watchdog voter.
// No dependencies.
`timescale 1ns / 1ps

package wlv_pkg;

  localparam int ASPECT_SLOTS = 6;
  localparam int IDX_W        = $clog2(ASPECT_SLOTS);
  localparam int ACNT_W       = 3;
  localparam int TIMEOUT_W    = 48;
  localparam int TIME_W       = 64;
  localparam int WORD_W       = 32;
  localparam int EXP_W        = 16;
  localparam int BIT_W        = $clog2(EXP_W);
  localparam int CFG_IDX_W    = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_A0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LAST = 3'd6;

  localparam logic [ACNT_W-1:0] ASPECT_COUNT_RST = ACNT_W'(ASPECT_SLOTS);

  // Controller states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_EVAL  = 6'b000100,
    S_SQ    = 6'b001000,
    S_MUL   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             chk_en;
    logic [IDX_W-1:0] idx;
    logic             pow_sq;
    logic             pow_mul;
    logic [BIT_W-1:0] bit_idx;
    logic             out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_op;
    logic fail_any;
    logic recipe_present;
  } status_t;

endpackage

// ===== rtl/wlv_ctrl.sv =====
// Controller state machine of the watchdog voter: sequencing and handshakes.
// Depends on wlv_pkg.
`timescale 1ns / 1ps

module wlv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  wlv_pkg::status_t status,
  output wlv_pkg::cmd_t    cmd
);

  wlv_pkg::state_t                state, state_next;
  logic [wlv_pkg::IDX_W-1:0]      idx, idx_next;
  logic [wlv_pkg::BIT_W-1:0]      bit_cnt, bit_cnt_next;
  logic                           out_free;

  // Output register can take a result when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != wlv_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    bit_cnt_next = bit_cnt;
    cmd          = '0;
    cmd.idx      = idx;
    cmd.bit_idx  = bit_cnt;
    case (state)
      wlv_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = wlv_pkg::S_CHECK;
        end
      end
      wlv_pkg::S_CHECK: begin
        if (status.start_op) begin
          state_next = wlv_pkg::S_DONE;
        end else begin
          cmd.chk_en = 1'b1;
          if (idx == wlv_pkg::IDX_W'(wlv_pkg::ASPECT_SLOTS - 1)) begin
            state_next = wlv_pkg::S_EVAL;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      wlv_pkg::S_EVAL: begin
        if (status.fail_any || !status.recipe_present) begin
          state_next = wlv_pkg::S_DONE;
        end else begin
          bit_cnt_next = wlv_pkg::BIT_W'(wlv_pkg::EXP_W - 1);
          state_next   = wlv_pkg::S_SQ;
        end
      end
      wlv_pkg::S_SQ: begin
        cmd.pow_sq = 1'b1;
        state_next = wlv_pkg::S_MUL;
      end
      wlv_pkg::S_MUL: begin
        cmd.pow_mul = 1'b1;
        if (bit_cnt == '0) begin
          state_next = wlv_pkg::S_DONE;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
          state_next   = wlv_pkg::S_SQ;
        end
      end
      wlv_pkg::S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = wlv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wlv_pkg::S_IDLE;
      end
    endcase
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wlv_pkg::S_IDLE;
      idx       <= '0;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      bit_cnt   <= bit_cnt_next;
      out_valid <= cmd.out_load || (out_valid && out_stall);
    end
  end

endmodule

// ===== rtl/wlv_dpath.sv =====
// Datapath of the watchdog voter: config registers, last-OK store, deadline
// check, shared 32-bit multiplier and output register. Depends on wlv_pkg.
`timescale 1ns / 1ps

module wlv_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  wlv_pkg::cmd_t                      cmd,
  output wlv_pkg::status_t                   status,
  input  logic                               cfg_we,
  input  logic [wlv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wlv_pkg::TIMEOUT_W-1:0]      cfg_data,
  input  logic                               operation,
  input  logic [wlv_pkg::TIME_W-1:0]         now_ns,
  input  logic [wlv_pkg::ASPECT_SLOTS-1:0]   ok_reports,
  input  logic                               recipe_present,
  input  logic [wlv_pkg::WORD_W-1:0]         recipe,
  output logic                               food_valid,
  output logic                               reset_demand,
  output logic [wlv_pkg::WORD_W-1:0]         food,
  output logic [wlv_pkg::ASPECT_SLOTS-1:0]   failed_aspects
);

  logic [wlv_pkg::ACNT_W-1:0]       aspect_count;
  logic [wlv_pkg::TIMEOUT_W-1:0]    timeouts [wlv_pkg::ASPECT_SLOTS];
  logic [wlv_pkg::TIME_W-1:0]       last_ok  [wlv_pkg::ASPECT_SLOTS];

  logic                             op_q;
  logic [wlv_pkg::TIME_W-1:0]       now_q;
  logic [wlv_pkg::ASPECT_SLOTS-1:0] reports_q;
  logic                             rp_q;
  logic [wlv_pkg::WORD_W-1:0]       recipe_q;
  logic [wlv_pkg::ASPECT_SLOTS-1:0] failed_q;
  logic [wlv_pkg::WORD_W-1:0]       acc;

  logic [wlv_pkg::ACNT_W-1:0]       used;
  logic                             in_use;
  logic [wlv_pkg::TIME_W:0]         diff;
  logic                             late;
  logic [wlv_pkg::WORD_W-1:0]       base;
  logic [wlv_pkg::WORD_W-1:0]       mul_b;
  logic [2*wlv_pkg::WORD_W-1:0]     product;
  logic [wlv_pkg::EXP_W-1:0]        exponent;
  logic                             exp_bit;
  logic [wlv_pkg::WORD_W-1:0]       rev;
  logic                             fail_any;

  // Saturate aspect count and test the current aspect
  assign used   = (aspect_count > wlv_pkg::ACNT_W'(wlv_pkg::ASPECT_SLOTS))
                  ? wlv_pkg::ACNT_W'(wlv_pkg::ASPECT_SLOTS) : aspect_count;
  assign in_use = (wlv_pkg::ACNT_W'(cmd.idx) < used);

  // Borrow flags time before last-OK; otherwise compare elapsed to timeout
  assign diff = {1'b0, now_q} - {1'b0, last_ok[cmd.idx]};
  assign late = diff[wlv_pkg::TIME_W] ||
                (diff[wlv_pkg::TIME_W-1:0] >
                 {{(wlv_pkg::TIME_W - wlv_pkg::TIMEOUT_W){1'b0}}, timeouts[cmd.idx]});

  // Shared multiplier: square, or multiply by the base
  assign base     = {8'd0, recipe_q[wlv_pkg::WORD_W-1:8]} | wlv_pkg::WORD_W'(1);
  assign mul_b    = cmd.pow_sq ? acc : base;
  assign product  = acc * mul_b;
  assign exponent = recipe_q[wlv_pkg::EXP_W-1:0];
  assign exp_bit  = exponent[cmd.bit_idx];

  // Bit-reverse the recipe
  always_comb begin
    for (int k = 0; k < wlv_pkg::WORD_W; k++) begin
      rev[k] = recipe_q[wlv_pkg::WORD_W-1-k];
    end
  end

  assign fail_any = (failed_q != '0);

  assign status.start_op       = op_q;
  assign status.fail_any       = fail_any;
  assign status.recipe_present = rp_q;

  // Config registers and last-OK store
  always_ff @(posedge clk) begin
    if (rst) begin
      aspect_count <= wlv_pkg::ASPECT_COUNT_RST;
      for (int i = 0; i < wlv_pkg::ASPECT_SLOTS; i++) begin
        timeouts[i] <= '0;
        last_ok[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == wlv_pkg::CFG_ASPECT_COUNT) begin
          aspect_count <= cfg_data[wlv_pkg::ACNT_W-1:0];
        end else if (cfg_index >= wlv_pkg::CFG_TIMEOUT_A0 &&
                     cfg_index <= wlv_pkg::CFG_TIMEOUT_LAST) begin
          timeouts[wlv_pkg::IDX_W'(cfg_index - wlv_pkg::CFG_TIMEOUT_A0)] <= cfg_data;
        end
      end
      if (cmd.load && operation) begin
        for (int i = 0; i < wlv_pkg::ASPECT_SLOTS; i++) begin
          last_ok[i] <= now_ns;
        end
      end else if (cmd.chk_en && in_use && reports_q[cmd.idx]) begin
        last_ok[cmd.idx] <= now_q;
      end
    end
  end

  // Capture the transfer, collect failures, run the exponent, load outputs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= operation;
      now_q     <= now_ns;
      reports_q <= ok_reports;
      rp_q      <= recipe_present;
      recipe_q  <= recipe;
      failed_q  <= '0;
      acc       <= wlv_pkg::WORD_W'(1);
    end else begin
      if (cmd.chk_en && in_use && !reports_q[cmd.idx] && late) begin
        failed_q[cmd.idx] <= 1'b1;
      end
      if (cmd.pow_sq || (cmd.pow_mul && exp_bit)) begin
        acc <= product[wlv_pkg::WORD_W-1:0];
      end
    end
    if (cmd.out_load) begin
      food_valid     <= !op_q && (fail_any || rp_q);
      reset_demand   <= !op_q && fail_any;
      failed_aspects <= op_q ? '0 : failed_q;
      food           <= (!op_q && !fail_any && rp_q) ? (acc ^ rev) : '0;
    end
  end

endmodule

// ===== rtl/watchdog_liveness_voter.sv =====
// Watchdog liveness voter top level: controller plus datapath, one result per item.
// Start item: check, then done. Clip: the six-aspect deadline scan and an evaluation,
// then done on a failure or no recipe, else the 16-bit square-and-multiply on one
// 32-bit multiplier (a square and a multiply state per exponent bit); one item at a time.
// A waiting result holds the next result in the done state, which also stalls the input.
// Reset (rst, synchronous): aspect_count 6, timeouts 0, last-OK times 0, both sides idle.
`timescale 1ns / 1ps

`include "watchdog_liveness_voter_assert.svh"

module watchdog_liveness_voter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wlv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wlv_pkg::TIMEOUT_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [wlv_pkg::TIME_W-1:0]         now_ns,
  input  logic [wlv_pkg::ASPECT_SLOTS-1:0]   ok_reports,
  input  logic                               recipe_present,
  input  logic [wlv_pkg::WORD_W-1:0]         recipe,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               food_valid,
  output logic                               reset_demand,
  output logic [wlv_pkg::WORD_W-1:0]         food,
  output logic [wlv_pkg::ASPECT_SLOTS-1:0]   failed_aspects
);

  wlv_pkg::cmd_t    cmd;
  wlv_pkg::status_t status;

  // Sequencing and handshakes
  wlv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  wlv_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .now_ns         (now_ns),
    .ok_reports     (ok_reports),
    .recipe_present (recipe_present),
    .recipe         (recipe),
    .food_valid     (food_valid),
    .reset_demand   (reset_demand),
    .food           (food),
    .failed_aspects (failed_aspects)
  );

  // A forced reset carries no food and always sends a message
  `WLV_ASSERT_SAME(a_reset_no_food, out_valid && reset_demand, food_valid && food == '0)
  // Failure mask and forced reset agree
  `WLV_ASSERT_SAME(a_fail_mask, out_valid, (failed_aspects != '0) == reset_demand)
  // Accepting a transfer makes the block busy
  `WLV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the watchdog liveness voter: a directed table, then random clips.
// Depends on wlv_pkg and the watchdog_liveness_voter top level; results are checked
// against an in-bench predictor of the deadline vote and the food computation.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 240;
  localparam int NUM_PHASES     = 6;
  localparam int MAX_REPORTS    = 10;

  localparam logic [wlv_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [wlv_pkg::TIMEOUT_W-1:0] MAX48      = '1;
  localparam logic [wlv_pkg::TIME_W-1:0]    TOP        = '1;
  localparam logic [wlv_pkg::TIME_W-1:0]    T48        = 64'h0001_0000_0000_0000;

  typedef enum logic {OP_CLIP = 1'b0, OP_START = 1'b1} vote_op_t;

  typedef struct packed {
    vote_op_t                          op;
    logic [wlv_pkg::TIME_W-1:0]        now;
    logic [wlv_pkg::ASPECT_SLOTS-1:0]  ok;
    logic                              has_recipe;
    logic [wlv_pkg::WORD_W-1:0]        recipe;
  } clip_t;

  typedef struct packed {
    logic                              feed;
    logic                              reset_req;
    logic [wlv_pkg::WORD_W-1:0]        food;
    logic [wlv_pkg::ASPECT_SLOTS-1:0]  failed;
  } verdict_t;

  // One row of the directed table: a register write or a clip, optionally with a known verdict
  typedef struct packed {
    logic                              is_write;
    logic [wlv_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [wlv_pkg::TIMEOUT_W-1:0]     reg_val;
    clip_t                             clip;
    logic                              known;
    verdict_t                          want;
  } vector_t;

  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              cfg_we         = 1'b0;
  logic [wlv_pkg::CFG_IDX_W-1:0]     cfg_index      = '0;
  logic [wlv_pkg::TIMEOUT_W-1:0]     cfg_data       = '0;
  logic                              in_valid       = 1'b0;
  logic                              in_stall;
  logic                              operation      = 1'b0;
  logic [wlv_pkg::TIME_W-1:0]        now_ns         = '0;
  logic [wlv_pkg::ASPECT_SLOTS-1:0]  ok_reports     = '0;
  logic                              recipe_present = 1'b0;
  logic [wlv_pkg::WORD_W-1:0]        recipe         = '0;
  logic                              out_valid;
  logic                              out_stall      = 1'b0;
  logic                              food_valid;
  logic                              reset_demand;
  logic [wlv_pkg::WORD_W-1:0]        food;
  logic [wlv_pkg::ASPECT_SLOTS-1:0]  failed_aspects;

  // Predictor state: configuration and per-aspect last-OK times
  logic [wlv_pkg::ACNT_W-1:0]    mdl_count;
  logic [wlv_pkg::TIMEOUT_W-1:0] mdl_timeout [wlv_pkg::ASPECT_SLOTS];
  logic [wlv_pkg::TIME_W-1:0]    mdl_last_ok [wlv_pkg::ASPECT_SLOTS];
  logic [wlv_pkg::TIME_W-1:0]    clip_clock = '0;

  verdict_t verdict_q [$];
  int       mismatches   = 0;
  int       snd_idle_pct = 22;
  int       rcv_idle_pct = 81;
  int       hold_asked   = 0;
  int       quiet_cycles = 0;

  watchdog_liveness_voter dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [wlv_pkg::TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Vote on one clip: refresh, deadline check, then forced reset, food or neither
  function automatic verdict_t vote_verdict(clip_t c);
    verdict_t                          v;
    logic [wlv_pkg::ASPECT_SLOTS-1:0]  late;
    logic [wlv_pkg::WORD_W-1:0]        base;
    logic [wlv_pkg::WORD_W-1:0]        acc;
    logic [wlv_pkg::WORD_W-1:0]        rev;
    int                                used;
    v    = '0;
    late = '0;
    if (c.op == OP_START) begin
      foreach (mdl_last_ok[i]) mdl_last_ok[i] = c.now;
      return v;
    end
    used = (mdl_count > wlv_pkg::ASPECT_SLOTS) ? wlv_pkg::ASPECT_SLOTS : int'(mdl_count);
    for (int i = 0; i < used; i++) begin
      if (c.ok[i]) begin
        mdl_last_ok[i] = c.now;
      end else if (c.now < mdl_last_ok[i] ||
                   c.now - mdl_last_ok[i] > wlv_pkg::TIME_W'(mdl_timeout[i])) begin
        late[i] = 1'b1;
      end
    end
    if (late != '0) begin
      v.feed      = 1'b1;
      v.reset_req = 1'b1;
      v.failed    = late;
    end else if (c.has_recipe) begin
      // Square-and-multiply over the low 16 recipe bits, modulo 2^32
      base = (c.recipe >> 8) | 32'd1;
      acc  = 32'd1;
      for (int b = wlv_pkg::EXP_W - 1; b >= 0; b--) begin
        acc = acc * acc;
        if (c.recipe[b]) acc = acc * base;
      end
      for (int k = 0; k < wlv_pkg::WORD_W; k++) rev[k] = c.recipe[wlv_pkg::WORD_W-1-k];
      v.feed = 1'b1;
      v.food = acc ^ rev;
    end
    return v;
  endfunction

  function automatic vector_t vec_reg(logic [wlv_pkg::CFG_IDX_W-1:0] idx,
                                      logic [wlv_pkg::TIMEOUT_W-1:0] val);
    vector_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = val;
    return r;
  endfunction

  function automatic vector_t vec_clip(vote_op_t op, logic [wlv_pkg::TIME_W-1:0] now,
                                       logic [wlv_pkg::ASPECT_SLOTS-1:0] ok, logic rp,
                                       logic [wlv_pkg::WORD_W-1:0] rcp);
    vector_t r;
    r      = '0;
    r.clip = '{op, now, ok, rp, rcp};
    return r;
  endfunction

  function automatic vector_t vec_known(vector_t r, logic fd, logic fr,
                                        logic [wlv_pkg::WORD_W-1:0] fw,
                                        logic [wlv_pkg::ASPECT_SLOTS-1:0] fl);
    r.known = 1'b1;
    r.want  = '{fd, fr, fw, fl};
    return r;
  endfunction

  // Random clip: mostly steady time steps with random reports, plus restarts and noise
  function automatic clip_t random_clip(logic [31:0] dmax, logic near_top);
    clip_t       c;
    int unsigned pick;
    pick         = $urandom_range(99);
    c.op         = OP_CLIP;
    c.has_recipe = ($urandom_range(4) < 3);
    c.recipe     = $urandom;
    for (int i = 0; i < wlv_pkg::ASPECT_SLOTS; i++) c.ok[i] = ($urandom_range(3) != 0);
    if (pick < 4) begin
      c.op  = OP_START;
      c.now = near_top ? TOP - wlv_pkg::TIME_W'($urandom_range(0, 1 << 20))
                       : ((pick < 2) ? rand64() : clip_clock);
    end else if (pick < 12) begin
      c.now = rand64();
      c.ok  = wlv_pkg::ASPECT_SLOTS'($urandom_range(0, 63));
    end else if (pick < 16) begin
      c.now = clip_clock - wlv_pkg::TIME_W'($urandom_range(1, 1000));
    end else begin
      c.now = clip_clock + wlv_pkg::TIME_W'($urandom_range(0, dmax));
    end
    clip_clock = c.now;
    return c;
  endfunction

  // Drain the block, then write one register and mirror it in the predictor
  task automatic write_reg(input logic [wlv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wlv_pkg::TIMEOUT_W-1:0] val);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == wlv_pkg::CFG_ASPECT_COUNT) begin
      mdl_count = val[wlv_pkg::ACNT_W-1:0];
    end else if (idx <= wlv_pkg::CFG_TIMEOUT_LAST) begin
      mdl_timeout[idx - wlv_pkg::CFG_TIMEOUT_A0] = val;
    end
  endtask

  // Offer one clip, hold it until the transfer, then queue its verdict
  task automatic push_item(input clip_t c, input logic known, input verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= c.op;
    now_ns         <= c.now;
    ok_reports     <= c.ok;
    recipe_present <= c.has_recipe;
    recipe         <= c.recipe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = vote_verdict(c);
    verdict_q.push_back(known ? want : v);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != holds_done) begin
        holds_done = hold_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest queued verdict
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {food_valid, reset_demand, food, failed_aspects};
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: feed=%0b reset=%0b food=%h failed=%b",
                   got.feed, got.reset_req, got.food, got.failed);
        end
      end else begin
        want = verdict_q.pop_front();
        if (got.feed !== want.feed || got.reset_req !== want.reset_req ||
            got.food !== want.food || got.failed !== want.failed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected feed=%0b reset=%0b food=%h failed=%b",
                     want.feed, want.reset_req, want.food, want.failed);
            $display("           got      feed=%0b reset=%0b food=%h failed=%b",
                     got.feed, got.reset_req, got.food, got.failed);
          end
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    vector_t                       vectors [$];
    logic [wlv_pkg::TIMEOUT_W-1:0] tmo;
    logic [wlv_pkg::ACNT_W-1:0]    cnt;
    int unsigned                   scale;
    logic [31:0]                   dmax;

    mdl_count = wlv_pkg::ASPECT_COUNT_RST;
    foreach (mdl_timeout[i]) mdl_timeout[i] = '0;
    foreach (mdl_last_ok[i]) mdl_last_ok[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, starting from reset values: timeouts zero, six aspects
    vectors.push_back(vec_known(vec_clip(OP_CLIP, 64'd0, 6'h00, 1'b0, 32'd0),
                                1'b0, 1'b0, 32'd0, 6'h00));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, 64'd1, 6'h00, 1'b0, 32'd0),
                                1'b1, 1'b1, 32'd0, 6'h3F));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, 64'd1, 6'h3F, 1'b1, 32'd0),
                                1'b1, 1'b0, 32'd1, 6'h00));
    vectors.push_back(vec_clip(OP_CLIP, 64'd1, 6'h00, 1'b1, 32'hFFFF_FFFF));
    vectors.push_back(vec_known(vec_clip(OP_START, TOP, 6'h00, 1'b0, 32'd0),
                                1'b0, 1'b0, 32'd0, 6'h00));
    // time behind last-OK fails every aspect and drops the recipe
    vectors.push_back(vec_known(vec_clip(OP_CLIP, 64'd0, 6'h00, 1'b1, 32'h1234_5678),
                                1'b1, 1'b1, 32'd0, 6'h3F));
    vectors.push_back(vec_known(vec_clip(OP_START, 64'h5555_5555_5555_5555, 6'h00, 1'b0,
                                         32'd0),
                                1'b0, 1'b0, 32'd0, 6'h00));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, 64'hAAAA_AAAA_AAAA_AAAA, 6'h2A, 1'b0,
                                         32'd0),
                                1'b1, 1'b1, 32'd0, 6'h15));
    for (int i = 0; i < wlv_pkg::ASPECT_SLOTS; i++) begin
      vectors.push_back(vec_reg(wlv_pkg::CFG_TIMEOUT_A0 + wlv_pkg::CFG_IDX_W'(i), MAX48));
    end
    // last-OK plus timeout beyond 2^64-1 never fails by lateness
    vectors.push_back(vec_known(vec_clip(OP_START, TOP - 64'd15, 6'h00, 1'b0, 32'd0),
                                1'b0, 1'b0, 32'd0, 6'h00));
    vectors.push_back(vec_clip(OP_CLIP, TOP, 6'h00, 1'b1, 32'h0000_FFFF));
    vectors.push_back(vec_known(vec_clip(OP_START, 64'd0, 6'h00, 1'b0, 32'd0),
                                1'b0, 1'b0, 32'd0, 6'h00));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, T48 - 64'd1, 6'h00, 1'b0, 32'd0),
                                1'b0, 1'b0, 32'd0, 6'h00));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, T48, 6'h01, 1'b0, 32'd0),
                                1'b1, 1'b1, 32'd0, 6'h3E));
    // aspect count above six saturates
    vectors.push_back(vec_reg(wlv_pkg::CFG_ASPECT_COUNT, 48'd7));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, T48 << 1, 6'h00, 1'b1, 32'h0F0F_0F0F),
                                1'b1, 1'b1, 32'd0, 6'h3F));
    // zero aspects: no refresh and no failure
    vectors.push_back(vec_reg(wlv_pkg::CFG_ASPECT_COUNT, 48'd0));
    vectors.push_back(vec_clip(OP_CLIP, 64'd0, 6'h3F, 1'b1, 32'hFFFF_0000));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, 64'd5, 6'h00, 1'b0, 32'd0),
                                1'b0, 1'b0, 32'd0, 6'h00));
    // one aspect in use: reports of the others are ignored
    vectors.push_back(vec_reg(wlv_pkg::CFG_ASPECT_COUNT, 48'd1));
    vectors.push_back(vec_reg(wlv_pkg::CFG_TIMEOUT_A0, 48'd0));
    vectors.push_back(vec_clip(OP_CLIP, T48, 6'h3E, 1'b1, 32'h8000_0001));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, T48 + 64'd1, 6'h3E, 1'b0, 32'd0),
                                1'b1, 1'b1, 32'd0, 6'h01));
    // write beyond the register list is dropped
    vectors.push_back(vec_reg(CFG_UNUSED, MAX48));
    vectors.push_back(vec_reg(wlv_pkg::CFG_ASPECT_COUNT, 48'd6));
    vectors.push_back(vec_clip(OP_CLIP, T48 + 64'd1, 6'h3F, 1'b1, 32'hDEAD_BEEF));
    vectors.push_back(vec_known(vec_clip(OP_CLIP, T48 + 64'd1, 6'h00, 1'b1, 32'd0),
                                1'b1, 1'b0, 32'd1, 6'h00));

    foreach (vectors[n]) begin
      if (vectors[n].is_write) begin
        write_reg(vectors[n].reg_idx, vectors[n].reg_val);
      end else begin
        push_item(vectors[n].clip, vectors[n].known, vectors[n].want);
      end
    end

    // Random phases, each under its own settings, with one idling pattern per pair of phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin cnt = 3'd6; scale = 1000;    dmax = 1000;         end
        1: begin cnt = 3'd3; scale = 1 << 20; dmax = 1 << 20;      end
        2: begin cnt = 3'd7; scale = 1000;    dmax = 32'hFFFF_FFFF; end
        3: begin cnt = 3'd1; scale = 1000;    dmax = 1;            end
        4: begin cnt = 3'd0; scale = 1000;    dmax = 1000;         end
        default: begin cnt = 3'd5; scale = 1 << 30; dmax = 1 << 30; end
      endcase
      for (int i = 0; i < wlv_pkg::ASPECT_SLOTS; i++) begin
        tmo = wlv_pkg::TIMEOUT_W'(scale / 2 + $urandom_range(0, scale));
        if (p == 2 || (p == 1 && i == 2)) tmo = MAX48;
        if (p == 3) tmo = '0;
        write_reg(wlv_pkg::CFG_TIMEOUT_A0 + wlv_pkg::CFG_IDX_W'(i), tmo);
      end
      tmo                      = wlv_pkg::TIMEOUT_W'(rand64());
      tmo[wlv_pkg::ACNT_W-1:0] = cnt;
      write_reg(wlv_pkg::CFG_ASPECT_COUNT, tmo);

      if (p < 2) begin
        snd_idle_pct = 22;
        rcv_idle_pct = 81;
      end else if (p < 4) begin
        snd_idle_pct = 81;
        rcv_idle_pct = 22;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // long receiver hold-off while clips keep coming
      if (p == 2 || p == 4) hold_asked++;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_item(random_clip(dmax, p == 2), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== watchdog_liveness_voter.f =====
+incdir+rtl
rtl/wlv_pkg.sv
rtl/wlv_ctrl.sv
rtl/wlv_dpath.sv
rtl/watchdog_liveness_voter.sv
sim/tb_top.sv
